// File: rtl/nscs_pkg.sv
// Package for the start code and emulation prevention stripper.
// It holds the byte patterns, the delay line depth and the header tracking type.
// No dependencies.
package nscs_pkg;

    // Byte patterns matched against the history
    localparam logic [31:0] START_CODE_WORD = 32'h0000_0001;
    localparam logic [23:0] EMULATION_WORD  = 24'h00_0003;
    localparam logic [31:0] HISTORY_RESET   = 32'hFFFF_FFFF;

    // Kept bytes wait this many places before they are emitted
    localparam int unsigned DELAY_DEPTH = 3;
    localparam int unsigned COUNT_W     = $clog2(DELAY_DEPTH + 1);

    // Header field positions
    localparam int unsigned LAYER_W = 6;
    localparam int unsigned TYPE_W  = 5;
    localparam int unsigned TYPE_LSB = 3;

    // Position in the header of the current unit
    typedef enum logic [1:0] {
        HDR_FIRST  = 2'd0,
        HDR_SECOND = 2'd1,
        HDR_DONE   = 2'd2
    } hdr_state_t;

endpackage

// File: rtl/nal_start_code_and_emulation_stripper.sv
// Top level of the start code and emulation prevention stripper.
// Depends on nscs_pkg for patterns, depth and the header state type.
//
// Usage:
//   Input channel in_valid/in_ready/in_byte carries one raw stream byte per
//   transaction. Result channel result_valid/result_ready carries one result
//   (out_valid, out_byte, unit_start, header_valid, layer_id, unit_type).
//   A byte produces a result only when it completes a four-byte start code
//   or pushes a payload byte out of the three-byte delay line inside a unit;
//   other bytes (emulation prevention bytes, bytes before the first start
//   code, bytes filling the delay line) produce nothing.
//   A result shows on result_valid in the cycle after its byte is
//   accepted. Throughput: one byte per cycle, set by the single result
//   register; in_ready stays high while that register is empty or is being
//   taken in the same cycle.
//   Stall: while a result waits and result_ready is low, in_ready is low and
//   the result holds unchanged.
//   Reset (rst_n low, asynchronous): history set to all ones, delay line
//   empty, outside any unit, result register empty.
//   There is no flush: the last kept bytes remain in the delay line.
module nal_start_code_and_emulation_stripper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          out_valid,
    output logic [7:0]                    out_byte,
    output logic                          unit_start,
    output logic                          header_valid,
    output logic [nscs_pkg::LAYER_W-1:0]  layer_id,
    output logic [nscs_pkg::TYPE_W-1:0]   unit_type
);

    localparam int unsigned CW = nscs_pkg::COUNT_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(nscs_pkg::DELAY_DEPTH);

    // State
    logic [31:0]              hist_reg, hist_next;
    logic [7:0]               pend_reg [nscs_pkg::DELAY_DEPTH];
    logic [7:0]               pend_next [nscs_pkg::DELAY_DEPTH];
    logic [CW-1:0]            count_reg, count_next;
    logic                     inside_reg, inside_next;
    nscs_pkg::hdr_state_t     hdr_reg, hdr_next;
    logic [7:0]               first_reg, first_next;

    // Result register
    logic                     res_valid_reg, res_valid_next;
    logic                     res_out_valid_reg;
    logic [7:0]               res_byte_reg;
    logic                     res_start_reg;
    logic                     res_hdr_reg;
    logic [nscs_pkg::LAYER_W-1:0] res_layer_reg;
    logic [nscs_pkg::TYPE_W-1:0]  res_type_reg;

    // Decisions for the byte being accepted
    logic        accept;
    logic [31:0] hist_shift;
    logic        is_start;
    logic        is_emu;
    logic        do_pop;
    logic        emit;
    logic        load_result;
    logic [7:0]  popped;

    // Result values for the accepted byte
    logic                     r_out_valid;
    logic [7:0]               r_byte;
    logic                     r_start;
    logic                     r_hdr;
    logic [nscs_pkg::LAYER_W-1:0] r_layer;
    logic [nscs_pkg::TYPE_W-1:0]  r_type;

    assign in_ready    = !res_valid_reg || result_ready;
    assign accept      = in_valid && in_ready;
    assign hist_shift  = {hist_reg[23:0], in_byte};
    assign is_start    = (hist_shift == nscs_pkg::START_CODE_WORD);
    assign is_emu      = (hist_shift[23:0] == nscs_pkg::EMULATION_WORD);
    assign do_pop      = !is_start && !is_emu && (count_reg == FULL_COUNT);
    assign popped      = pend_reg[0];
    assign emit        = do_pop && inside_reg;
    assign load_result = accept && (emit || is_start);

    // Next state of history, delay line and header tracking
    always_comb
    begin
        hist_next   = hist_reg;
        pend_next   = pend_reg;
        count_next  = count_reg;
        inside_next = inside_reg;
        hdr_next    = hdr_reg;
        first_next  = first_reg;
        if (accept)
        begin
            hist_next = hist_shift;
            if (is_start)
            begin
                count_next  = '0;
                inside_next = 1'b1;
                hdr_next    = nscs_pkg::HDR_FIRST;
            end
            else if (!is_emu)
            begin
                if (do_pop)
                begin
                    // Advance the delay line and push the new byte
                    for (int i = 0; i < nscs_pkg::DELAY_DEPTH - 1; i++)
                    begin
                        pend_next[i] = pend_reg[i + 1];
                    end
                    pend_next[nscs_pkg::DELAY_DEPTH - 1] = in_byte;
                    if (inside_reg)
                    begin
                        unique case (hdr_reg)
                            nscs_pkg::HDR_FIRST:
                            begin
                                first_next = popped;
                                hdr_next   = nscs_pkg::HDR_SECOND;
                            end
                            nscs_pkg::HDR_SECOND:
                            begin
                                hdr_next = nscs_pkg::HDR_DONE;
                            end
                            default:
                            begin
                                hdr_next = hdr_reg;
                            end
                        endcase
                    end
                end
                else
                begin
                    // Fill the delay line
                    pend_next[count_reg[$clog2(nscs_pkg::DELAY_DEPTH)-1:0]] = in_byte;
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    // Result fields for the accepted byte
    always_comb
    begin
        r_out_valid = emit;
        r_byte      = emit ? popped : 8'h00;
        r_start     = is_start;
        r_hdr       = 1'b0;
        r_layer     = '0;
        r_type      = '0;
        unique case (hdr_reg)
            nscs_pkg::HDR_SECOND:
            begin
                if (emit)
                begin
                    r_hdr   = 1'b1;
                    r_layer = first_reg[nscs_pkg::LAYER_W-1:0];
                    r_type  = popped[nscs_pkg::TYPE_LSB +: nscs_pkg::TYPE_W];
                end
            end
            default:
            begin
                r_hdr = 1'b0;
            end
        endcase
    end

    // Hold a result until it is taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_result)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= nscs_pkg::HISTORY_RESET;
            count_reg     <= '0;
            inside_reg    <= 1'b0;
            hdr_reg       <= nscs_pkg::HDR_FIRST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            hist_reg      <= hist_next;
            count_reg     <= count_next;
            inside_reg    <= inside_next;
            hdr_reg       <= hdr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        first_reg <= first_next;
        if (load_result)
        begin
            res_out_valid_reg <= r_out_valid;
            res_byte_reg      <= r_byte;
            res_start_reg     <= r_start;
            res_hdr_reg       <= r_hdr;
            res_layer_reg     <= r_layer;
            res_type_reg      <= r_type;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_valid    = res_out_valid_reg;
    assign out_byte     = res_byte_reg;
    assign unit_start   = res_start_reg;
    assign header_valid = res_hdr_reg;
    assign layer_id     = res_layer_reg;
    assign unit_type    = res_type_reg;

endmodule

// File: rtl/nscs_checker.sv
// Port-level checker for the stripper, bound to the top level.
// Depends on nscs_pkg for field widths.
module nscs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic                          out_valid,
    input logic [7:0]                    out_byte,
    input logic                          unit_start,
    input logic                          header_valid,
    input logic [nscs_pkg::LAYER_W-1:0]  layer_id,
    input logic [nscs_pkg::TYPE_W-1:0]   unit_type
);

    // A stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(out_byte)
            && $stable(unit_start) && $stable(header_valid))
        else $error("result changed while stalled");

    // Every result carries a payload byte or a unit start, never both
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (out_valid != unit_start))
        else $error("result kind malformed");

    // Header fields come only with a payload byte
    a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && header_valid |-> out_valid)
        else $error("header without payload byte");

    // A unit start result has zeroed payload and header fields
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && unit_start |-> out_byte == 8'h00 && layer_id == '0
            && unit_type == '0 && !header_valid)
        else $error("unit start carries payload");

    // Nothing arrives on the result side without a byte accepted before it
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(in_valid && in_ready))
        else $error("result without accepted byte");

endmodule

bind nal_start_code_and_emulation_stripper nscs_checker u_nscs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .unit_start   (unit_start),
    .header_valid (header_valid),
    .layer_id     (layer_id),
    .unit_type    (unit_type)
);

// File: verif/nal_start_code_and_emulation_stripper_tb.sv
// Testbench for nal_start_code_and_emulation_stripper: drives raw stream bytes,
// predicts start codes, stripped payload and header fields, and checks every result.
// Depends on nscs_pkg and the top level RTL.
module nal_start_code_and_emulation_stripper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One result transaction as seen on the output ports
    typedef struct packed {
        logic                         out_valid;
        logic [7:0]                   out_byte;
        logic                         unit_start;
        logic                         header_valid;
        logic [nscs_pkg::LAYER_W-1:0] layer_id;
        logic [nscs_pkg::TYPE_W-1:0]  unit_type;
    } stripped_t;

    // One raw byte to send; hold_for_drain makes the sender wait for all results
    typedef struct packed {
        logic [7:0] data;
        logic       hold_for_drain;
    } feed_t;

    localparam int unsigned LONG_HOLD   = 80;
    localparam int unsigned HOLD_AFTER  = 60;
    localparam int unsigned STREAM_LEN  = 760;
    localparam logic [7:0]  DIRECTED [25] = '{
        8'h12, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01, 8'h7F, 8'hFF,
        8'h00, 8'h00, 8'h03, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
        8'hC0, 8'h07, 8'h55, 8'hAA, 8'hFF
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [7:0]                   in_byte = 8'h00;
    logic                         result_valid;
    logic                         result_ready = 1'b0;
    logic                         out_valid;
    logic [7:0]                   out_byte;
    logic                         unit_start;
    logic                         header_valid;
    logic [nscs_pkg::LAYER_W-1:0] layer_id;
    logic [nscs_pkg::TYPE_W-1:0]  unit_type;

    // Stimulus and expectations
    feed_t       raw_stream_q[$];
    stripped_t   stripped_q[$];
    feed_t       next_item;
    logic        drain_pending = 1'b0;
    int unsigned error_count = 0;

    // Shadow state of the stripper
    logic [31:0]          byte_hist = nscs_pkg::HISTORY_RESET;
    logic [7:0]           delay_line [nscs_pkg::DELAY_DEPTH];
    int unsigned          delay_fill = 0;
    logic                 in_unit = 1'b0;
    nscs_pkg::hdr_state_t hdr_pos = nscs_pkg::HDR_FIRST;
    logic [7:0]           first_hdr;

    // Idle control
    logic [15:0] cycle_no = '0;
    int unsigned tx_gap;
    int unsigned rx_gap;
    int unsigned rx_taken;
    logic        long_hold_done;
    wire         quiet = (cycle_no[8:7] == 2'b11);

    nal_start_code_and_emulation_stripper i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .unit_start   (unit_start),
        .header_valid (header_valid),
        .layer_id     (layer_id),
        .unit_type    (unit_type)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1'b1;
    end

    // Advance the shadow state by one byte and queue the result it causes
    function automatic void strip_byte(input logic [7:0] b);
        stripped_t  r;
        logic [7:0] popped;
        r = '0;
        byte_hist = {byte_hist[23:0], b};
        if (byte_hist == nscs_pkg::START_CODE_WORD)
        begin
            r.unit_start = 1'b1;
            delay_fill   = 0;
            in_unit      = 1'b1;
            hdr_pos      = nscs_pkg::HDR_FIRST;
        end
        else if (byte_hist[23:0] != nscs_pkg::EMULATION_WORD)
        begin
            if (delay_fill == nscs_pkg::DELAY_DEPTH)
            begin
                popped = delay_line[0];
                for (int i = 0; i < nscs_pkg::DELAY_DEPTH - 1; i++)
                    delay_line[i] = delay_line[i + 1];
                delay_line[nscs_pkg::DELAY_DEPTH - 1] = b;
                if (in_unit)
                begin
                    r.out_valid = 1'b1;
                    r.out_byte  = popped;
                    case (hdr_pos)
                        nscs_pkg::HDR_FIRST:
                        begin
                            first_hdr = popped;
                            hdr_pos   = nscs_pkg::HDR_SECOND;
                        end
                        nscs_pkg::HDR_SECOND:
                        begin
                            r.header_valid = 1'b1;
                            r.layer_id     = first_hdr[nscs_pkg::LAYER_W-1:0];
                            r.unit_type    = popped[nscs_pkg::TYPE_LSB +: nscs_pkg::TYPE_W];
                            hdr_pos        = nscs_pkg::HDR_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            else
            begin
                delay_line[delay_fill] = b;
                delay_fill++;
            end
        end
        if (r.out_valid || r.unit_start)
            stripped_q.push_back(r);
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void feed(input logic [7:0] b);
        raw_stream_q.push_back('{data: b, hold_for_drain: drain_pending});
        drain_pending = 1'b0;
    endfunction

    // Append one well-formed unit: optional extra zeros, start code, header, payload
    function automatic void feed_unit();
        int unsigned len;
        int unsigned r;
        repeat ($urandom_range(0, 2)) feed(8'h00);
        feed(8'h00);
        feed(8'h00);
        feed(8'h00);
        feed(8'h01);
        feed(8'($urandom_range(0, 255)));
        feed(8'($urandom_range(0, 255)));
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                feed(8'h00);
                feed(8'h00);
                feed(8'h03);
            end
            else if (r < 40)
                feed(8'h00);
            else if (r < 50)
                feed(8'($urandom_range(0, 3)));
            else
                feed(8'($urandom_range(0, 255)));
        end
    endfunction

    // Append noise or a sequence that looks like a start code but is not one
    function automatic void feed_broken();
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 8)) feed(8'($urandom_range(0, 255)));
            1:
            begin
                feed(8'h00);
                feed(8'h00);
                feed(8'h01);
            end
            2:
            begin
                feed(8'h00);
                feed(8'h00);
                feed(8'h00);
                feed(8'($urandom_range(2, 255)));
            end
            default:
            begin
                feed(8'h00);
                feed(8'h00);
                feed(8'h00);
                feed(8'h00);
                feed(8'h03);
            end
        endcase
    endfunction

    // Drive input transactions from the stream queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            tx_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                strip_byte(in_byte);
            if (in_valid && !in_ready)
            begin
                // hold the offered byte until it is taken
            end
            else if (tx_gap != 0)
            begin
                tx_gap   <= tx_gap - 1;
                in_valid <= 1'b0;
            end
            else if (raw_stream_q.size() == 0
                     || (raw_stream_q[0].hold_for_drain && stripped_q.size() != 0))
                in_valid <= 1'b0;
            else
            begin
                next_item = raw_stream_q.pop_front();
                in_valid <= 1'b1;
                in_byte  <= next_item.data;
                if (!quiet)
                    tx_gap <= pick_gap();
            end
        end
    end

    // Drive result_ready, with one long hold-off to back up the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready   <= 1'b0;
            rx_gap         <= 0;
            rx_taken       <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
                rx_taken <= rx_taken + 1;
            if (!long_hold_done && rx_taken >= HOLD_AFTER)
            begin
                long_hold_done <= 1'b1;
                rx_gap         <= LONG_HOLD;
                result_ready   <= 1'b0;
            end
            else if (rx_gap != 0)
            begin
                rx_gap       <= rx_gap - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (!quiet)
                    rx_gap <= pick_gap();
            end
        end
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected 0x%0h actual 0x%0h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (stripped_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none actual byte 0x%0h start %0b",
                         $time, out_byte, unit_start);
                error_count++;
            end
            else
            begin
                check_field("out_valid", stripped_q[0].out_valid, out_valid);
                check_field("out_byte", stripped_q[0].out_byte, out_byte);
                check_field("unit_start", stripped_q[0].unit_start, unit_start);
                check_field("header_valid", stripped_q[0].header_valid, header_valid);
                check_field("layer_id", stripped_q[0].layer_id, layer_id);
                check_field("unit_type", stripped_q[0].unit_type, unit_type);
                void'(stripped_q.pop_front());
            end
        end
    end

    // Build the stream, release reset, wait for the end and report
    initial
    begin
        foreach (DIRECTED[i])
            feed(DIRECTED[i]);
        drain_pending = 1'b1;
        while (raw_stream_q.size() < STREAM_LEN)
        begin
            if (raw_stream_q.size() > STREAM_LEN / 2 && raw_stream_q.size() < STREAM_LEN / 2 + 40)
                drain_pending = 1'b1;
            if ($urandom_range(0, 9) < 7)
                feed_unit();
            else
                feed_broken();
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (raw_stream_q.size() != 0 || in_valid)
            @(posedge clk);
        while (stripped_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (error_count == 0 && stripped_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #4_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, stripped_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/nscs_pkg.sv
rtl/nal_start_code_and_emulation_stripper.sv
rtl/nscs_checker.sv
verif/nal_start_code_and_emulation_stripper_tb.sv
